// File: rtl/wme_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the WSPR message encoder.
package wme_pkg;

	localparam logic [7:0] NumPos    = 8'd162;
	localparam logic [7:0] LastPos   = 8'd161;
	localparam logic [4:0] LastGroup = 5'd26;
	localparam logic [2:0] LastStep  = 3'd5;

	localparam logic [31:0] PolyA = 32'hF2D05351;
	localparam logic [31:0] PolyB = 32'hE4613C47;

	localparam logic [7:0] Space = 8'h20;

	// Sync vector, symbol 0 leftmost.
	localparam logic [0:161] SyncVec = {
		26'b11000000100011100010010111, 16'b1000000010010100,
		26'b00001011001101000110100001, 16'b1010101010010010,
		26'b11000110101000100000100100, 16'b1110110011010001,
		26'b11000001010011000000011010, 10'b1100011000
	};

	typedef enum logic [1:0] {
		PK_IDLE,
		PK_CHECK,
		PK_HORNER,
		PK_DONE
	} pack_state_t;

	typedef enum logic {
		ENC_IDLE,
		ENC_RUN
	} enc_state_t;

	typedef struct packed {
		logic        ok;
		logic [49:0] word;
	} msg_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] pos;
		logic       dbit;
		logic       last;
		logic       ok;
	} wr_ev_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] code;
	} chr_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	// '0'-'9' -> 0-9, 'A'-'Z' -> 10-35, space -> 36
	function automatic chr_t char_code(input logic [7:0] ch);
		chr_t r;
		r.ok   = 1'b0;
		r.code = '0;
		if (is_digit(ch)) begin
			r.ok   = 1'b1;
			r.code = 6'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			r.ok   = 1'b1;
			r.code = 6'(ch - 8'h37);
		end else if (ch == Space) begin
			r.ok   = 1'b1;
			r.code = 6'd36;
		end
		return r;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7 - k] = v[k];
		end
		return r;
	endfunction

	// pos / 6 by reciprocal, exact for pos below 162
	function automatic logic [4:0] pos_row(input logic [7:0] pos);
		logic [15:0] p;
		p = 16'(pos) * 16'd171;
		return p[14:10];
	endfunction

	function automatic logic [2:0] pos_col(input logic [7:0] pos);
		logic [7:0] r;
		r = pos - 8'(pos_row(pos)) * 8'd6;
		return r[2:0];
	endfunction

	function automatic logic [5:0] sync_bits(input logic [4:0] grp);
		logic [7:0] base;
		logic [5:0] r;
		base = 8'(grp) * 8'd6;
		for (int i = 0; i < 6; i++) begin
			r[i] = SyncVec[base + 8'(i)];
		end
		return r;
	endfunction

	function automatic logic [5:0] horner_mul(input logic [2:0] step);
		logic [5:0] m;
		case (step)
			3'd1:    m = 6'd36;
			3'd2:    m = 6'd10;
			default: m = 6'd27;
		endcase
		return m;
	endfunction

	// power 0..60 moved to its legal level, plus the offset of 64
	function automatic logic [6:0] power_code(input logic [5:0] d);
		logic [5:0] rem;
		logic [6:0] base;
		logic [6:0] r;
		rem  = d;
		base = 7'(d) + 7'd64;
		for (int k = 0; k < 6; k++) begin
			if (rem >= 6'd10) begin
				rem = rem - 6'd10;
			end
		end
		case (rem)
			6'd1, 6'd4, 6'd8: r = base - 7'd1;
			6'd2, 6'd6, 6'd9: r = base + 7'd1;
			6'd5:             r = base + 7'd2;
			default:          r = base;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/wme_packer.sv
`timescale 1ns / 1ps
// Message intake: callsign normalization, validation and packing into the 50-bit word.
module wme_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  logic [47:0]           call_text,
	input  logic [3:0]            call_len,
	input  logic [31:0]           locator_text,
	input  logic signed [7:0]     power_dbm,
	output logic                  enc_valid,
	output wme_pkg::msg_t         enc_msg,
	input  logic                  enc_ready
);

	wme_pkg::pack_state_t state_q, state_d;

	logic [47:0] call_q;
	logic [3:0]  len_q;
	logic [31:0] loc_q;
	logic [7:0]  pwr_q;

	logic [5:0]  term_q [0:5];
	logic [27:0] acc_q;
	logic [2:0]  step_q;
	logic [7:0]  lt_q, lu_q;
	logic [14:0] nloc_q;
	logic [6:0]  nd_q;
	logic        ok_q;

	logic [7:0]         raw [0:5];
	logic [7:0]         cs  [0:5];
	wme_pkg::chr_t      cc  [0:5];
	logic [7:0]         lch [0:3];
	logic               d1, d2, call_ok, loc_ok, pwr_ok, all_ok;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			raw[k] = call_q[47 - 8 * k -: 8];
		end
		d1 = wme_pkg::is_digit(raw[1]);
		d2 = wme_pkg::is_digit(raw[2]);
		// third character a digit: keep; else shift right by one behind a space
		cs[0] = d2 ? raw[0] : wme_pkg::Space;
		for (int k = 1; k < 6; k++) begin
			if (d2) begin
				cs[k] = (4'(k) < len_q) ? raw[k] : wme_pkg::Space;
			end else begin
				cs[k] = (4'(k - 1) < len_q) ? raw[k - 1] : wme_pkg::Space;
			end
		end
		for (int k = 0; k < 6; k++) begin
			cc[k] = wme_pkg::char_code(cs[k]);
		end
		call_ok = (len_q >= 4'd3) && (len_q <= 4'd6) && (d2 || (d1 && len_q <= 4'd5))
			&& cc[0].ok
			&& cc[1].ok && (cc[1].code < 6'd36)
			&& cc[2].ok && (cc[2].code < 6'd10)
			&& cc[3].ok && (cc[3].code >= 6'd10)
			&& cc[4].ok && (cc[4].code >= 6'd10)
			&& cc[5].ok && (cc[5].code >= 6'd10);
		for (int k = 0; k < 4; k++) begin
			lch[k] = loc_q[31 - 8 * k -: 8];
		end
		loc_ok = (lch[0] >= 8'h41) && (lch[0] <= 8'h52)
			&& (lch[1] >= 8'h41) && (lch[1] <= 8'h52)
			&& wme_pkg::is_digit(lch[2]) && wme_pkg::is_digit(lch[3]);
		pwr_ok = !pwr_q[7] && (pwr_q <= 8'd60);
		all_ok = call_ok && loc_ok && pwr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wme_pkg::PK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		msg_stall = 1'b1;
		enc_valid = 1'b0;
		unique case (state_q)
			wme_pkg::PK_IDLE: begin
				msg_stall = 1'b0;
				if (msg_valid) begin
					state_d = wme_pkg::PK_CHECK;
				end
			end
			wme_pkg::PK_CHECK: begin
				state_d = all_ok ? wme_pkg::PK_HORNER : wme_pkg::PK_DONE;
			end
			wme_pkg::PK_HORNER: begin
				if (step_q == wme_pkg::LastStep) begin
					state_d = wme_pkg::PK_DONE;
				end
			end
			wme_pkg::PK_DONE: begin
				enc_valid = 1'b1;
				if (enc_ready) begin
					state_d = wme_pkg::PK_IDLE;
				end
			end
			default: state_d = wme_pkg::PK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == wme_pkg::PK_IDLE && msg_valid) begin
			call_q <= call_text;
			len_q  <= call_len;
			loc_q  <= locator_text;
			pwr_q  <= $unsigned(power_dbm);
		end
		if (state_q == wme_pkg::PK_CHECK) begin
			ok_q   <= all_ok;
			acc_q  <= 28'(cc[0].code);
			step_q <= 3'd1;
			for (int k = 0; k < 3; k++) begin
				term_q[k] <= cc[k].code;
			end
			for (int k = 3; k < 6; k++) begin
				term_q[k] <= cc[k].code - 6'd10;
			end
			lt_q <= 8'd179 - 8'd10 * (lch[0] - 8'h41) - (lch[2] - 8'h30);
			lu_q <= 8'd10 * (lch[1] - 8'h41) + (lch[3] - 8'h30);
			nd_q <= wme_pkg::power_code(pwr_q[5:0]);
		end
		if (state_q == wme_pkg::PK_HORNER) begin
			acc_q  <= 28'(acc_q * 28'(wme_pkg::horner_mul(step_q))) + 28'(term_q[step_q]);
			step_q <= step_q + 3'd1;
			nloc_q <= 15'(16'(lt_q) * 16'd180 + 16'(lu_q));
		end
	end

	assign enc_msg.ok   = ok_q;
	assign enc_msg.word = {acc_q, nloc_q, nd_q};

endmodule

// File: rtl/wme_conv_enc.sv
`timescale 1ns / 1ps
// K=32 rate 1/2 convolutional encoder with bit-reversal interleave addressing.
module wme_conv_enc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enc_valid,
	input  wme_pkg::msg_t     enc_msg,
	output logic              enc_ready,
	input  logic              bank_free,
	output wme_pkg::wr_ev_t   ev
);

	wme_pkg::enc_state_t state_q, state_d;

	logic [49:0] word_q;
	logic [31:0] sr_q;
	logic [7:0]  idx_q;
	logic [7:0]  cnt_q;

	logic [31:0] sr_next;
	logic [7:0]  rev_a, rev_b;
	logic        skip, phase, take;

	assign sr_next = {sr_q[30:0], word_q[49]};
	assign rev_a   = wme_pkg::rev8(idx_q);
	assign rev_b   = wme_pkg::rev8(idx_q + 8'd1);
	// odd indices may map past the end; the next even one never does
	assign skip    = rev_a >= wme_pkg::NumPos;
	assign phase   = cnt_q[0];
	assign take    = enc_valid && enc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wme_pkg::ENC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		enc_ready = 1'b0;
		ev        = '0;
		unique case (state_q)
			wme_pkg::ENC_IDLE: begin
				enc_ready = bank_free;
				if (enc_valid && bank_free) begin
					if (enc_msg.ok) begin
						state_d = wme_pkg::ENC_RUN;
					end else begin
						// rejection takes a bank with no data
						ev.vld  = 1'b1;
						ev.last = 1'b1;
					end
				end
			end
			wme_pkg::ENC_RUN: begin
				ev.vld  = 1'b1;
				ev.ok   = 1'b1;
				ev.pos  = skip ? rev_b : rev_a;
				ev.dbit = phase ? ^(sr_q & wme_pkg::PolyB) : ^(sr_next & wme_pkg::PolyA);
				ev.last = cnt_q == wme_pkg::LastPos;
				if (ev.last) begin
					state_d = wme_pkg::ENC_IDLE;
				end
			end
			default: state_d = wme_pkg::ENC_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == wme_pkg::ENC_IDLE) begin
			if (take) begin
				word_q <= enc_msg.word;
				sr_q   <= '0;
				idx_q  <= '0;
				cnt_q  <= '0;
			end
		end else begin
			idx_q <= idx_q + (skip ? 8'd2 : 8'd1);
			cnt_q <= cnt_q + 8'd1;
			if (!phase) begin
				sr_q   <= sr_next;
				word_q <= {word_q[48:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/wme_sym_store.sv
`timescale 1ns / 1ps
// Ping-pong symbol buffer: read-modify-write bit placement and group readout.
module wme_sym_store (
	input  logic              clk,
	input  logic              arst_n,
	input  wme_pkg::wr_ev_t   ev,
	output logic              bank_free,
	output logic              sym_valid,
	input  logic              sym_stall,
	output logic              msg_ok,
	output logic [4:0]        group_index,
	output logic [1:0]        sym_a,
	output logic [1:0]        sym_b,
	output logic [1:0]        sym_c,
	output logic [1:0]        sym_d,
	output logic [1:0]        sym_e,
	output logic [1:0]        sym_f,
	output logic              last_group
);

	logic [5:0] mem [0:63];

	logic       wbank_q, rbank_q;
	logic [1:0] full_q, okb_q;

	// write side
	logic [4:0] row_a;
	logic [2:0] col_a;
	logic       vld_s1, bank_s1, dbit_s1, last_s1, ok_s1;
	logic [4:0] row_s1;
	logic [2:0] col_s1;
	logic [5:0] rdata_s1;
	logic [5:0] base_b, merged_b;
	logic [5:0] addr_b;
	logic       wr_en;
	logic       wr_en_q;
	logic [5:0] wr_addr_q;
	logic [5:0] wr_data_q;

	// read side
	logic [4:0] rrow_q;
	logic       rd_pend_s1, rd_ok_s1, rd_last_s1;
	logic [4:0] rd_grp_s1;
	logic [5:0] rd_data_s1;
	logic       out_free, load, issue, rd_last;

	logic       ok_q, last_q, valid_q;
	logic [4:0] group_q;
	logic [5:0] data_q, sync_q;

	assign bank_free = !full_q[wbank_q];
	assign row_a     = wme_pkg::pos_row(ev.pos);
	assign col_a     = wme_pkg::pos_col(ev.pos);

	assign addr_b = {bank_s1, row_s1};
	assign wr_en  = vld_s1 && ok_s1;

	always_comb begin
		// forward the previous write, which the read of this row missed
		base_b = (wr_en_q && wr_addr_q == addr_b) ? wr_data_q : rdata_s1;
		merged_b = base_b;
		merged_b[col_s1] = dbit_s1;
	end

	assign out_free = !valid_q || !sym_stall;
	assign load     = rd_pend_s1 && out_free;
	assign issue    = full_q[rbank_q] && (!rd_pend_s1 || load);
	assign rd_last  = !okb_q[rbank_q] || rrow_q == wme_pkg::LastGroup;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_b] <= merged_b;
		end
		rdata_s1 <= mem[{wbank_q, row_a}];
		if (issue) begin
			rd_data_s1 <= mem[{rbank_q, rrow_q}];
		end
	end

	always_ff @(posedge clk) begin
		bank_s1   <= wbank_q;
		row_s1    <= row_a;
		col_s1    <= col_a;
		dbit_s1   <= ev.dbit;
		last_s1   <= ev.last;
		ok_s1     <= ev.ok;
		wr_addr_q <= addr_b;
		wr_data_q <= merged_b;
		if (issue) begin
			rd_grp_s1  <= okb_q[rbank_q] ? rrow_q : '0;
			rd_ok_s1   <= okb_q[rbank_q];
			rd_last_s1 <= rd_last;
		end
		if (load) begin
			ok_q    <= rd_ok_s1;
			last_q  <= rd_last_s1;
			group_q <= rd_grp_s1;
			data_q  <= rd_ok_s1 ? rd_data_s1 : '0;
			sync_q  <= rd_ok_s1 ? wme_pkg::sync_bits(rd_grp_s1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			wr_en_q    <= 1'b0;
			wbank_q    <= 1'b0;
			rbank_q    <= 1'b0;
			full_q     <= '0;
			okb_q      <= '0;
			rrow_q     <= '0;
			rd_pend_s1 <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			vld_s1  <= ev.vld;
			wr_en_q <= wr_en;
			if (ev.vld && ev.last) begin
				wbank_q <= ~wbank_q;
			end
			if (vld_s1 && last_s1) begin
				full_q[bank_s1] <= 1'b1;
				okb_q[bank_s1]  <= ok_s1;
			end
			if (issue) begin
				rd_pend_s1 <= 1'b1;
				if (rd_last) begin
					full_q[rbank_q] <= 1'b0;
					rbank_q         <= ~rbank_q;
					rrow_q          <= '0;
				end else begin
					rrow_q <= rrow_q + 5'd1;
				end
			end else if (load) begin
				rd_pend_s1 <= 1'b0;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!sym_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign sym_valid   = valid_q;
	assign msg_ok      = ok_q;
	assign group_index = group_q;
	assign last_group  = last_q;
	assign sym_a       = {data_q[0], sync_q[0]};
	assign sym_b       = {data_q[1], sync_q[1]};
	assign sym_c       = {data_q[2], sync_q[2]};
	assign sym_d       = {data_q[3], sync_q[3]};
	assign sym_e       = {data_q[4], sync_q[4]};
	assign sym_f       = {data_q[5], sync_q[5]};

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && ok_s1) |-> !full_q[bank_s1])
		else $error("bit written into a bank awaiting readout");

	a_fill_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		ev.vld |-> !full_q[wbank_q])
		else $error("encoder targets a full bank");

	a_last_is_26: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && ok_q && last_q) |-> (group_q == wme_pkg::LastGroup))
		else $error("final group of a message is not group 26");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !ok_q) |-> (last_q && group_q == 5'd0 && data_q == 6'd0
			&& sync_q == 6'd0))
		else $error("malformed rejection item");

endmodule

// File: rtl/wspr_message_encoder.sv
`timescale 1ns / 1ps
// WSPR message encoder top level: intake/packer, convolutional encoder, symbol buffer.
// A valid message passes a check, 5 packing steps, a handoff, 162 encoder bits and the
// buffer before its first group comes out; a rejected message gives its single item.
// The encoder sends one coded bit per cycle to the write port, and it takes a new message
// only after the last bit of the previous one and only when a bank is free.
// Reset clears all control state; buffer contents are not cleared (each row is rewritten).
module wspr_message_encoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  logic [47:0]       call_text,
	input  logic [3:0]        call_len,
	input  logic [31:0]       locator_text,
	input  logic signed [7:0] power_dbm,
	output logic              sym_valid,
	input  logic              sym_stall,
	output logic              msg_ok,
	output logic [4:0]        group_index,
	output logic [1:0]        sym_a,
	output logic [1:0]        sym_b,
	output logic [1:0]        sym_c,
	output logic [1:0]        sym_d,
	output logic [1:0]        sym_e,
	output logic [1:0]        sym_f,
	output logic              last_group
);

	// Packed message handoff: the packer holds it until the encoder has a free bank.
	logic            enc_valid;
	logic            enc_ready;
	wme_pkg::msg_t   enc_msg;

	// One coded bit per cycle toward the buffer, with its interleaved position.
	wme_pkg::wr_ev_t ev;
	logic            bank_free;

	// Validate, normalize and pack; accept a new item as soon as the last one is handed on.
	wme_packer u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.call_text    (call_text),
		.call_len     (call_len),
		.locator_text (locator_text),
		.power_dbm    (power_dbm),
		.enc_valid    (enc_valid),
		.enc_msg      (enc_msg),
		.enc_ready    (enc_ready)
	);

	// Run 81 steps, two parity bits each, plus a rejection marker for bad messages.
	wme_conv_enc u_conv_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (enc_valid),
		.enc_msg   (enc_msg),
		.enc_ready (enc_ready),
		.bank_free (bank_free),
		.ev        (ev)
	);

	// Two banks of 27 six-bit rows: one fills while the other drains to the output.
	wme_sym_store u_sym_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev          (ev),
		.bank_free   (bank_free),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.msg_ok      (msg_ok),
		.group_index (group_index),
		.sym_a       (sym_a),
		.sym_b       (sym_b),
		.sym_c       (sym_c),
		.sym_d       (sym_d),
		.sym_e       (sym_e),
		.sym_f       (sym_f),
		.last_group  (last_group)
	);

endmodule
